>>> design/wif_pkg.sv
package wif_pkg;

  localparam int PIX_W = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MODE_W = 3;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_REG_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_MEAN9 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN12 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LAPLACE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GRADIENT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 3'd4;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_MEAN9;
  localparam int WIDTH_RESET = 1024;
  localparam int HEIGHT_RESET = 768;

  localparam logic OP_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Sums and constant-reciprocal division for the two mean modes.
  localparam int SUM_W = 12;
  localparam int PROD_W = 24;
  localparam int REM_W = 4;
  localparam int RECIP_SHIFT = 15;
  localparam logic [SUM_W-1:0] RECIP9 = 12'd3641;
  localparam logic [SUM_W-1:0] RECIP12 = 12'd2731;
  localparam logic [SUM_W-1:0] ROUND9 = 12'd4;
  localparam logic [REM_W-1:0] HALF12 = 4'd6;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef struct packed {
    logic operation;
    logic [PIX_W-1:0] pixel_in;
  } wif_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic frame_end;
  } wif_out_t;

  typedef struct packed {
    logic valid;
    logic has_out;
    logic interior;
    logic frame_end;
  } wif_ctrl_t;

  // Index 0..8 is row * 3 + column, row 0 above, column 0 left.
  typedef logic [8:0][PIX_W-1:0] wif_win_t;

endpackage

>>> design/wif_line_store.sv
module wif_line_store
  import wif_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [2*PIX_W-1:0]   wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [2*PIX_W-1:0]   rdata
);

  logic [2*PIX_W-1:0] mem [DEPTH];

  // A write to the address being read is passed straight to the read register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/wif_front.sv
module wif_front
  import wif_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  wif_in_t          item,
  input  logic             restart,
  input  logic [COL_W-1:0] wlast,
  input  logic [ROW_W-1:0] hlast,
  output wif_win_t         win,
  output wif_ctrl_t        ctrl
);

  logic [COL_W-1:0] col, col_next, pc, rd_addr;
  logic [ROW_W-1:0] row, row_next, pr;
  logic in_frame, ignore, step, has_out, interior, fend;
  logic [PIX_W-1:0] top_px, mid_px, bot_px;
  logic [2*PIX_W-1:0] rd_data;

  always_comb begin
    in_frame = row <= hlast;
    ignore = (item.operation == OP_DRAIN) && in_frame;
    step = accept && !ignore;
    has_out = (row >= ROW_W'(2)) || (row == ROW_W'(1) && col != '0);
    if (col != '0) begin
      pr = row - ROW_W'(1);
      pc = col - COL_W'(1);
    end else begin
      pr = row - ROW_W'(2);
      pc = wlast;
    end
    interior = (pr != '0) && (pr < hlast) && (pc != '0) && (pc < wlast);
    fend = has_out && (pr == hlast) && (pc == wlast);
    {top_px, mid_px} = rd_data;
    bot_px = in_frame ? item.pixel_in : '0;
    col_next = col;
    row_next = row;
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (step) begin
      if (fend) begin
        col_next = '0;
        row_next = '0;
      end else if (col == wlast) begin
        col_next = '0;
        row_next = row + ROW_W'(1);
      end else begin
        col_next = col + COL_W'(1);
      end
    end
    rd_addr = rst ? '0 : col_next;
  end

  wif_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_store (
    .clk(clk),
    .we(step && in_frame),
    .waddr(col),
    .wdata({mid_px, bot_px}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      ctrl <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      ctrl.valid <= step;
      ctrl.has_out <= has_out;
      ctrl.interior <= interior;
      ctrl.frame_end <= fend;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= top_px;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= mid_px;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= bot_px;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (ctrl.valid && ctrl.has_out && ctrl.frame_end) |-> (col == '0 && row == '0))
    else $error("position counters not cleared after the last pixel of a frame");

  assert property (@(posedge clk) disable iff (rst)
    (col <= wlast) && ({1'b0, row} <= {1'b0, hlast} + (ROW_W + 1)'(2)))
    else $error("input position outside the frame and its drain");

endmodule

>>> design/wif_filter.sv
module wif_filter
  import wif_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [MODE_W-1:0] mode,
  input  wif_win_t          win,
  input  wif_ctrl_t         ctrl_in,
  output logic              push,
  output wif_out_t          result,
  output logic              stage_valid
);

  localparam int LAP_W = PIX_W + 2;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, b, c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Element 0 is the smallest, element 2 the largest.
  function automatic logic [2:0][PIX_W-1:0] sort3(input logic [PIX_W-1:0] a, b, c);
    logic [PIX_W-1:0] x0, x1, y;
    logic [2:0][PIX_W-1:0] s;
    x0 = min2(a, b);
    x1 = max2(a, b);
    s[0] = min2(x0, c);
    y = max2(x0, c);
    s[1] = min2(x1, y);
    s[2] = max2(x1, y);
    return s;
  endfunction

  // First stage: sums, contour values and sorted rows.
  logic [SUM_W-1:0] sum9, sum12;
  logic [LAP_W-1:0] lap_a, lap_b, lap_d;
  logic [PIX_W-1:0] lap, g1, g2, gm, grad;
  logic [2:0][2:0][PIX_W-1:0] rows;

  always_comb begin
    sum9 = '0;
    for (int i = 0; i < 9; i++) begin
      sum9 = sum9 + SUM_W'(win[i]);
    end
    sum12 = sum9 + SUM_W'({win[4], 1'b0}) + SUM_W'(win[4]);
    lap_a = {win[4], 2'b00};
    lap_b = LAP_W'(win[1]) + LAP_W'(win[3]) + LAP_W'(win[5]) + LAP_W'(win[7]);
    lap_d = (lap_a > lap_b) ? lap_a - lap_b : lap_b - lap_a;
    lap = (lap_d > LAP_W'(PIX_MAX >> 2)) ? PIX_MAX : {lap_d[PIX_W-3:0], 2'b00};
    g1 = (win[4] > win[5]) ? win[4] - win[5] : win[5] - win[4];
    g2 = (win[4] > win[1]) ? win[4] - win[1] : win[1] - win[4];
    gm = max2(g1, g2);
    grad = (gm > (PIX_MAX >> 2)) ? PIX_MAX : {gm[PIX_W-3:0], 2'b00};
    for (int k = 0; k < 3; k++) begin
      rows[k] = sort3(win[3*k], win[3*k+1], win[3*k+2]);
    end
  end

  wif_ctrl_t ctrl2;
  logic [SUM_W-1:0] sum9_r, sum12_r;
  logic [PIX_W-1:0] lap_r, grad_r, ctr_r;
  logic [2:0][2:0][PIX_W-1:0] rows_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl2 <= '0;
    end else begin
      ctrl2 <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    sum9_r <= sum9 + ROUND9;
    sum12_r <= sum12;
    lap_r <= lap;
    grad_r <= grad;
    ctr_r <= win[4];
    rows_r <= rows;
  end

  // Second stage: divisions by constant, median merge and mode select.
  logic [PROD_W-1:0] prod9, prod12;
  logic [PIX_W-1:0] q9, q12, m12, lo_max, mid_med, hi_min, med, val;
  logic [REM_W-1:0] r12;
  logic rnd;

  always_comb begin
    prod9 = PROD_W'(sum9_r) * PROD_W'(RECIP9);
    q9 = prod9[RECIP_SHIFT +: PIX_W];
    prod12 = PROD_W'(sum12_r) * PROD_W'(RECIP12);
    q12 = prod12[RECIP_SHIFT +: PIX_W];
    r12 = REM_W'(sum12_r - (SUM_W'(q12) << 3) - (SUM_W'(q12) << 2));
    rnd = (r12 > HALF12) || (r12 == HALF12 && q12[0]);
    m12 = q12 + PIX_W'(rnd);
    lo_max = max2(max2(rows_r[0][0], rows_r[1][0]), rows_r[2][0]);
    mid_med = med3(rows_r[0][1], rows_r[1][1], rows_r[2][1]);
    hi_min = min2(min2(rows_r[0][2], rows_r[1][2]), rows_r[2][2]);
    med = med3(lo_max, mid_med, hi_min);
    if (!ctrl2.interior) begin
      val = ctr_r;
    end else begin
      case (mode)
        MODE_MEAN9: val = q9;
        MODE_MEAN12: val = m12;
        MODE_LAPLACE: val = lap_r;
        MODE_GRADIENT: val = grad_r;
        MODE_MEDIAN: val = med;
        default: val = ctr_r;
      endcase
    end
    push = ctrl2.valid && ctrl2.has_out;
    result.pixel_out = val;
    result.frame_end = ctrl2.frame_end;
    stage_valid = ctrl2.valid;
  end

endmodule

>>> design/wif_out_fifo.sv
module wif_out_fifo
  import wif_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wif_out_t             wdata,
  input  logic                 ready,
  output logic                 valid,
  output wif_out_t             rdata,
  output logic [OUT_CNT_W-1:0] count
);

  wif_out_t entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic pop;

  assign valid = count != '0;
  assign rdata = entries[rd_ptr];
  assign pop = valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    push |-> (count < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result written into a full output buffer");

endmodule

>>> design/window3x3_image_filter_unit.sv
// 3x3 window image filter.
// Pixels enter on the pixel channel (valid/ready) in raster order, one item
// per clock while pixel_ready is high; each is a frame pixel or a drain item.
// The filtered pixel for raster position p leaves on the result channel
// after the item with frame index p + width + 1 has entered; drain items
// after the last pixel push out the final width + 1 results, and the last
// one carries frame_end. Border pixels pass through unchanged.
// A result becomes valid after the item that completes it is accepted and
// passes one filter register stage, then the output buffer write.
// The line store is a single-port-write, single-read RAM of MAX_WIDTH
// entries, read one column ahead so that its registered output is ready
// when the next item arrives.
// Up to four results wait in an output buffer; pixel_ready drops only in
// reset or when the buffer, the window stage and the filter stage together
// hold four items, so a stalled receiver lets the pipeline fill before input
// stops. Configuration writes are registered; writing width or height
// restarts the frame. Reset clears the position counters, the pipeline and
// the output buffer and loads the default mode, width and height.
module window3x3_image_filter_unit
  import wif_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  wif_in_t               pixel_item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output wif_out_t              result_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int HEIGHT_INIT = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
  localparam int PEND_W = OUT_CNT_W + 1;

  logic [MODE_W-1:0] filter_mode;
  logic [COL_W-1:0] wlast, w_set;
  logic [ROW_W-1:0] hlast, h_set;
  logic [WIDTH_REG_W-1:0] w_val;
  logic [HEIGHT_REG_W-1:0] h_val;
  logic restart, accept, push, s2_valid;
  logic [OUT_CNT_W-1:0] count;
  logic [PEND_W-1:0] pending;
  wif_win_t win;
  wif_ctrl_t ctrl1;
  wif_out_t push_item;

  always_comb begin
    w_val = cfg_data[WIDTH_REG_W-1:0];
    h_val = cfg_data[HEIGHT_REG_W-1:0];
    if (w_val == '0) begin
      w_set = '0;
    end else if (32'(w_val) > 32'(MAX_WIDTH)) begin
      w_set = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_set = COL_W'(w_val - WIDTH_REG_W'(1));
    end
    if (h_val == '0) begin
      h_set = '0;
    end else if (32'(h_val) > 32'(MAX_HEIGHT)) begin
      h_set = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_set = ROW_W'(h_val - HEIGHT_REG_W'(1));
    end
    restart = cfg_write && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_RESET;
      wlast <= COL_W'(WIDTH_INIT - 1);
      hlast <= ROW_W'(HEIGHT_INIT - 1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILTER_MODE: filter_mode <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH: wlast <= w_set;
        REG_IMAGE_HEIGHT: hlast <= h_set;
        default: ;
      endcase
    end
  end

  assign pending = PEND_W'(count) + PEND_W'(ctrl1.valid) + PEND_W'(s2_valid);
  assign pixel_ready = !rst && (pending < PEND_W'(OUT_DEPTH));
  assign accept = pixel_valid && pixel_ready;

  wif_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(pixel_item),
    .restart(restart),
    .wlast(wlast),
    .hlast(hlast),
    .win(win),
    .ctrl(ctrl1)
  );

  wif_filter u_filter (
    .clk(clk),
    .rst(rst),
    .mode(filter_mode),
    .win(win),
    .ctrl_in(ctrl1),
    .push(push),
    .result(push_item),
    .stage_valid(s2_valid)
  );

  wif_out_fifo u_out (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata(push_item),
    .ready(result_ready),
    .valid(result_valid),
    .rdata(result_item),
    .count(count)
  );

  assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(OUT_DEPTH))
    else $error("more items in flight than the output buffer can hold");

endmodule
